[hw/rtl/mbt_pkg.sv]
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types and constants for the multiset bag table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

  // Fixed field widths of the request and result words
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_O_W = 5;

  // Defaults for the top-level parameters
  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_EMIT
  } mbt_state_t;

endpackage : mbt_pkg

`default_nettype wire

[hw/rtl/mbt_req_if.sv]
// ----------------------------------------------------------------------------
// mbt_req_if
// Request channel: valid/ready handshake carrying request kind and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_req_if;
  logic                      valid;
  logic                      ready;
  logic [mbt_pkg::REQ_W-1:0] req_type;
  logic [mbt_pkg::VAL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface : mbt_req_if

`default_nettype wire

[hw/rtl/mbt_rsp_if.sv]
// ----------------------------------------------------------------------------
// mbt_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [mbt_pkg::CNT_O_W-1:0] frequency;
  logic                        present;
  logic [mbt_pkg::CNT_O_W-1:0] size;

  modport source (output valid, output success, output frequency, output present,
                  output size, input ready);
  modport sink   (input valid, input success, input frequency, input present,
                  input size, output ready);
endinterface : mbt_rsp_if

`default_nettype wire

[hw/rtl/multiset_bag_table_unit.sv]
// ----------------------------------------------------------------------------
// multiset_bag_table_unit
// Fixed-capacity unordered multiset kept as a packed array in one memory.
// ----------------------------------------------------------------------------
// The bag holds up to CAPACITY values in a single-port-write, registered-read
// memory plus an entry count; one request word is taken at a time and gives
// one result word. Add and clear are accepted, then load their result. Query
// walks the n stored entries one memory read per cycle; remove walks until the
// first match, reads the last entry and writes it into the hole. A result
// waits in an output register, so the next request word is taken while the
// previous result has not yet been collected. No clearing pass is needed
// after reset: only entries below the count are ever used.
`default_nettype none

module multiset_bag_table_unit #(
  parameter int unsigned CAPACITY    = mbt_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = mbt_pkg::VALUE_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  mbt_req_if.sink     in_ch,
  mbt_rsp_if.source   out_ch
);
  import mbt_pkg::*;

  // Stored width: the value field never carries more than VAL_W bits
  localparam int unsigned SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Entry memory
  logic [SW-1:0] entry_mem [CAPACITY];
  logic [SW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  // Control and working registers
  mbt_state_t    state_r, state_nxt;
  req_kind_t     kind_r, kind_nxt;
  logic [SW-1:0] val_r, val_nxt;
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [CW-1:0] freq_r, freq_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ok_r, ok_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [CNT_O_W-1:0] out_freq_r, out_freq_nxt;
  logic               out_pres_r, out_pres_nxt;
  logic [CNT_O_W-1:0] out_size_r, out_size_nxt;

  logic          accept;
  logic [SW-1:0] in_val;
  logic [CW-1:0] last_cnt;
  logic [CW-1:0] scan_next;
  logic          hit;
  logic          scan_end;
  logic          load_out;

  assign accept    = in_ch.valid && (state_r == ST_IDLE);
  assign in_val    = in_ch.value[SW-1:0];
  assign last_cnt  = count_r - CW'(1);
  assign scan_next = CW'(scan_idx_r) + CW'(1);
  assign hit       = (rd_data_r == val_r);
  assign scan_end  = (scan_next == count_r);
  assign load_out  = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.success   = out_ok_r;
  assign out_ch.frequency = out_freq_r;
  assign out_ch.present   = out_pres_r;
  assign out_ch.size      = out_size_r;

  // Next state, memory port control and result capture
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    val_nxt      = val_r;
    scan_idx_nxt = scan_idx_r;
    hit_idx_nxt  = hit_idx_r;
    freq_nxt     = freq_r;
    count_nxt    = count_r;
    ok_nxt       = ok_r;
    rd_addr      = scan_idx_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[IW-1:0];
    wr_data      = in_val;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          kind_nxt     = req_kind_t'(in_ch.req_type);
          val_nxt      = in_val;
          scan_idx_nxt = '0;
          freq_nxt     = '0;
          state_nxt    = ST_EMIT;
          unique case (req_kind_t'(in_ch.req_type))
            REQ_ADD: begin
              // append when there is room
              ok_nxt = (count_r < CW'(CAPACITY));
              if (count_r < CW'(CAPACITY)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_REMOVE: begin
              ok_nxt = 1'b0;
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            REQ_QUERY: begin
              ok_nxt = 1'b1;
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            REQ_CLEAR: begin
              ok_nxt    = 1'b1;
              count_nxt = '0;
            end
            default: begin
              ok_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // compare the entry read last cycle, fetch the next one
        rd_addr = scan_next[IW-1:0];
        if (kind_r == REQ_REMOVE) begin
          if (hit) begin
            hit_idx_nxt = scan_idx_r;
            count_nxt   = last_cnt;
            rd_addr     = last_cnt[IW-1:0];
            state_nxt   = ST_MOVE;
          end else if (scan_end) begin
            state_nxt = ST_EMIT;
          end else begin
            scan_idx_nxt = scan_next[IW-1:0];
          end
        end else begin
          if (hit) begin
            freq_nxt = freq_r + CW'(1);
          end
          if (scan_end) begin
            state_nxt = ST_EMIT;
          end else begin
            scan_idx_nxt = scan_next[IW-1:0];
          end
        end
      end

      ST_MOVE: begin
        // fill the hole with the last entry
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r;
        wr_data   = rd_data_r;
        ok_nxt    = 1'b1;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: hold until taken, load a new word when free
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_freq_nxt  = out_freq_r;
    out_pres_nxt  = out_pres_r;
    out_size_nxt  = out_size_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok_r;
      out_freq_nxt  = CNT_O_W'(freq_r);
      out_pres_nxt  = (freq_r != '0);
      out_size_nxt  = CNT_O_W'(count_r);
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    scan_idx_r <= scan_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    freq_r     <= freq_nxt;
    ok_r       <= ok_nxt;
    out_ok_r   <= out_ok_nxt;
    out_freq_r <= out_freq_nxt;
    out_pres_r <= out_pres_nxt;
    out_size_r <= out_size_nxt;
  end

endmodule : multiset_bag_table_unit

`default_nettype wire
